// ===== hdl/iopdt_pkg.sv =====
// Shared types, constants and default-decode functions for the I/O port decode table.
// Used by the front end, command queue, back end and top level; no dependencies.
`default_nettype none

package iopdt_pkg;

  // Stream widths
  localparam int KEY_MAX_BITS  = 14;
  localparam int LOW_KEY_BITS  = 10;
  localparam int IN_DATA_BITS  = 48;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 24;

  // Command queue geometry
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // Item selector codes carried on tuser
  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_WRITE,
    OP_RESTORE
  } op_t;

  // Classified command passed from front end to back end
  typedef struct packed {
    op_t                     op;
    logic [KEY_MAX_BITS-1:0] key;
    logic [7:0]              value;
  } cmd_t;

  // Built-in device code of one port and direction; zero means no device.
  // The low-byte 0xC0-and-above rule comes first, so the 0xFE and 0xFD
  // arms never fire; they stay as the decode rules list them.
  function automatic logic [7:0] default_code(input logic [15:0] port, input logic rd);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] code;
    lo   = port[7:0];
    hi   = port[15:8];
    code = 8'h00;
    if (lo >= 8'hC0) begin
      code = lo;
    end else if (lo == 8'hFE) begin
      code = rd ? 8'h40 : 8'hC2;
    end else if (lo == 8'h1C && rd && hi < 8'h80) begin
      code = 8'h1C;
    end else if (lo == 8'h1D && !rd && hi < 8'h80) begin
      code = 8'h1D;
    end else if (lo == 8'h1E && !rd && hi < 8'h80) begin
      code = 8'h1E;
    end else if (lo == 8'hBD && rd && hi == 8'hFF) begin
      code = 8'h1C;
    end else if (lo == 8'hBD && !rd && hi == 8'hDF) begin
      code = 8'h1D;
    end else if (lo == 8'hBD && !rd && hi == 8'hBF) begin
      code = 8'h1E;
    end else if (lo == 8'hFD && hi == 8'hFF) begin
      code = rd ? 8'h52 : 8'h90;
    end else if (lo == 8'hFD && hi == 8'hBF && !rd) begin
      code = 8'h91;
    end else if (lo == 8'h82 && !rd && hi < 8'h80) begin
      code = 8'hE8;
    end else if (lo == 8'hA2 && !rd && hi < 8'h80) begin
      code = 8'hE9;
    end else if (lo >= 8'h50 && lo <= 8'h57) begin
      code = 8'h20 + {5'b00000, lo[2:0]};
    end else if (lo == 8'h1F) begin
      code = 8'h10;
    end else if (lo == 8'h3F) begin
      code = 8'h11;
    end else if (lo == 8'h5F) begin
      code = 8'h12;
    end else if (lo == 8'h7F) begin
      code = 8'h13;
    end else if (lo == 8'h88 || lo == 8'h89 || lo == 8'h8F) begin
      code = lo;
    end
    return code;
  endfunction

  // Default table content of one low key (bit 9 direction, 8:7 A15:A14,
  // 6:5 A6:A5, 4 A13, 3 A7, 2:0 A2:A0). Walking ports upward, the last
  // nonzero code wins. Only the 0xBD rules look at A12:A8 beyond A15, and
  // they need A12:A8 all ones, which is also the highest high byte, so the
  // winner sits at A12:A8 = ones with the highest A4:A3 that decodes.
  function automatic logic [7:0] base_code(input logic [LOW_KEY_BITS-1:0] lk);
    logic [15:0] port;
    logic [7:0]  code;
    logic [7:0]  cand;
    logic        found;
    code  = 8'h00;
    found = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      port = {lk[8:7], lk[4], 5'b11111, lk[3], lk[6:5], 2'(i), lk[2:0]};
      cand = default_code(port, lk[9]);
      if (!found && cand != 8'h00) begin
        code  = cand;
        found = 1'b1;
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/iopdt_front.sv =====
// Front end of the I/O port decode table: unpacks input transactions,
// classifies them by selector and forms the masked table key. Uses iopdt_pkg.
`default_nettype none

module iopdt_front
  import iopdt_pkg::*;
#(
  parameter int KEY_BITS = 14
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IN_USER_BITS-1:0] in_mode,
  input  logic [IN_DATA_BITS-1:0] in_data,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  logic                    cmd_ready
);

  localparam logic [KEY_MAX_BITS-1:0] KeyMask =
    KEY_MAX_BITS'((32'd1 << KEY_BITS) - 32'd1);

  logic [15:0]             port_address;
  logic                    is_read;
  logic [1:0]              cfg_bits;
  logic                    page_bit;
  logic                    dos_flag;
  logic [KEY_MAX_BITS-1:0] entry_key;
  logic [7:0]              entry_value;
  logic [KEY_MAX_BITS-1:0] lookup_key;

  // Unpack the data fields
  assign port_address = in_data[15:0];
  assign is_read      = in_data[16];
  assign cfg_bits     = in_data[18:17];
  assign page_bit     = in_data[19];
  assign dos_flag     = in_data[20];
  assign entry_key    = in_data[34:21];
  assign entry_value  = in_data[42:35];

  // Pack the lookup key and trim it to the table size
  assign lookup_key = {cfg_bits, page_bit, dos_flag, is_read,
                       port_address[15:14], port_address[6:5], port_address[13],
                       port_address[7], port_address[2:0]} & KeyMask;

  // Every transaction is taken when the queue has room; unused codes drop here
  assign in_ready = cmd_ready;

  // Classify by selector
  always_comb begin
    cmd_valid = 1'b0;
    cmd.op    = OP_LOOKUP;
    cmd.key   = lookup_key;
    cmd.value = entry_value;
    unique case (in_mode)
      MODE_LOOKUP: begin
        cmd_valid = in_valid;
      end
      MODE_WRITE: begin
        cmd_valid = in_valid;
        cmd.op    = OP_WRITE;
        cmd.key   = entry_key & KeyMask;
      end
      MODE_RESTORE: begin
        cmd_valid = in_valid;
        cmd.op    = OP_RESTORE;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/iopdt_queue.sv =====
// Short command queue between the front and back ends of the decode table.
// Holds classified commands in order; uses iopdt_pkg.
`default_nettype none

module iopdt_queue
  import iopdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam logic [QUEUE_PTR_BITS:0] CountMax = (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);

  cmd_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      push;
  logic                      pop;

  assign push_ready = (count != CountMax);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountMax)
    else $error("queue occupancy above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue occupancy did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue occupancy did not shrink on pop");

endmodule

`default_nettype wire

// ===== hdl/iopdt_back.sv =====
// Back end of the decode table: table memory, default fill sequencer,
// lookup read stage and output register. Uses iopdt_pkg.
`default_nettype none

module iopdt_back
  import iopdt_pkg::*;
#(
  parameter int KEY_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  cmd_t                     cmd,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_DATA_BITS-1:0] out_data
);

  localparam int TableDepth = 1 << KEY_BITS;

  typedef enum logic {
    ST_RUN,
    ST_FILL
  } state_t;

  state_t                  state;
  logic [KEY_BITS-1:0]     fill_cnt;
  logic [7:0]              mem [TableDepth];
  logic [7:0]              mem_q;
  logic                    s1_vld;
  logic [KEY_MAX_BITS-1:0] s1_key;

  logic                    s1_advance;
  logic                    s1_free;
  logic                    pop;
  logic                    mem_we;
  logic                    mem_re;
  logic [KEY_BITS-1:0]     mem_wa;
  logic [7:0]              mem_wd;

  // Issue control: the fill owns the memory; a lookup needs room in the read stage
  always_comb begin
    s1_advance = s1_vld && (!out_valid || out_ready);
    s1_free    = !s1_vld || s1_advance;
    cmd_ready  = (state == ST_RUN) && ((cmd.op != OP_LOOKUP) || s1_free);
    pop        = cmd_valid && cmd_ready;
    mem_re     = pop && (cmd.op == OP_LOOKUP);
    if (state == ST_FILL) begin
      mem_we = 1'b1;
      mem_wa = fill_cnt;
      mem_wd = base_code(fill_cnt[LOW_KEY_BITS-1:0]);
    end else begin
      mem_we = pop && (cmd.op == OP_WRITE);
      mem_wa = cmd.key[KEY_BITS-1:0];
      mem_wd = cmd.value;
    end
  end

  // Table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[cmd.key[KEY_BITS-1:0]];
    end
  end

  // Sequencer state, read stage and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_cnt  <= '0;
      s1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (pop && cmd.op == OP_RESTORE) begin
            state    <= ST_FILL;
            fill_cnt <= '0;
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == {KEY_BITS{1'b1}}) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
      if (mem_re) begin
        s1_vld <= 1'b1;
      end else if (s1_advance) begin
        s1_vld <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the read stage and output register
  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1_key <= cmd.key;
    end
    if (s1_advance) begin
      out_data <= OUT_DATA_BITS'({s1_key, mem_q});
    end
  end

  a_fill_blocks_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !pop)
    else $error("command issued while the default fill runs");

  a_restore_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.op == OP_RESTORE) |=> (state == ST_FILL && fill_cnt == '0))
    else $error("restore did not start a fill from key zero");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_vld && out_valid && !out_ready) |=> (s1_vld && out_valid))
    else $error("pending lookup result lost under output stall");

endmodule

`default_nettype wire

// ===== hdl/io_port_decode_table.sv =====
// I/O port decode table: a 2^KEY_BITS-entry table of 8-bit device codes indexed by a key
// packed from configuration bits, page bit, DOS flag, direction and port address bits. A
// lookup (tuser 0) returns the stored code and the key; a write (tuser 1) stores entry_value
// at entry_key; a restore (tuser 2) rebuilds the default contents; tuser 3 is taken and
// dropped. One transaction per cycle is sustained while m_tready stays high and no fill runs;
// a lookup result passes through the queue, the registered table read and the output register
// on its way to m_tdata. A restore, and the fill that follows reset, holds the back end while
// it rewrites all 2^KEY_BITS entries (16384 at the default), one memory write per cycle
// through the single table write port; the front end keeps taking up to four transactions
// into its queue meanwhile and then deasserts s_tready.
`default_nettype none

module io_port_decode_table
  import iopdt_pkg::*;
#(
  parameter int KEY_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // port_address[15:0], is_read[16], cfg_bits[18:17], page_bit[19], dos_flag[20],
  // entry_key[34:21], entry_value[42:35], zero[47:43]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // mode[1:0]
  input  logic [IN_USER_BITS-1:0]  s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // device_code[7:0], table_key[21:8], zero[23:22]
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic queue_valid;
  logic queue_ready;
  cmd_t queue_cmd;

  // Classify incoming transactions
  iopdt_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_data   (s_tdata),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  // Decouple front and back
  iopdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  // Execute commands against the table
  iopdt_back #(
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== test/io_port_decode_table_tb.sv =====
// Self-checking testbench for io_port_decode_table: lookups, table writes, restores, unused mode.
// Depends on iopdt_pkg for stream widths and mode codes; predicts results with its own table.

module io_port_decode_table_tb
  import iopdt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int N_RANDOM  = 1025;
  localparam int LIMIT     = 1000000;
  localparam int DRAIN     = 32;
  localparam int IDLE_PCT  = 12;

  // One input transaction, unpacked from the stream fields
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic        rd;
    logic [1:0]  cfg;
    logic        page;
    logic        dos;
    logic [13:0] ekey;
    logic [7:0]  eval;
  } io_item_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [13:0] key;
  } decode_res_t;

  // Directed row: item plus an optional hand-typed device code
  typedef struct packed {
    io_item_t   item;
    logic       typed;
    logic [7:0] code;
  } dir_row_t;

  localparam int N_DIRECTED = 27;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata;
  logic [IN_USER_BITS-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  // Predictor state
  logic [7:0]  dev_table [0:16383];
  logic [7:0]  dflt_low [0:1023];
  decode_res_t pending_results [$];
  logic [13:0] written_keys [$];

  int  errors;
  int  cycles;
  bit  steady;
  bit  stim_done;

  dir_row_t directed [N_DIRECTED] = '{
    // reset contents at the extremes of the key
    '{'{MODE_LOOKUP, 16'h0000, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b1, 8'h00},
    '{'{MODE_LOOKUP, 16'hFFFF, 1'b1, 2'd3, 1'b1, 1'b1, 14'h0000, 8'h00}, 1'b1, 8'hFF},
    // low byte 0xFE falls under the 0xC0-and-above rule
    '{'{MODE_LOOKUP, 16'hFFFE, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b1, 8'hFE},
    '{'{MODE_LOOKUP, 16'hFFFE, 1'b0, 2'd1, 1'b0, 1'b1, 14'h0000, 8'h00}, 1'b1, 8'hFE},
    '{'{MODE_LOOKUP, 16'h7FFE, 1'b1, 2'd2, 1'b1, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    // 0xBD and 0xFD ports keyed on the high byte
    '{'{MODE_LOOKUP, 16'hFFBD, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'hDFBD, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'hBFBD, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'hFFFD, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'hBFFD, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    // disk controller style ports below 0x8000
    '{'{MODE_LOOKUP, 16'h001C, 1'b1, 2'd0, 1'b0, 1'b1, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h001D, 1'b0, 2'd0, 1'b0, 1'b1, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h001E, 1'b0, 2'd0, 1'b0, 1'b1, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h0082, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h00A2, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h0053, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h7F1F, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h003F, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h007F, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h0088, 1'b1, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    // unused mode with every field at its maximum: no result, no change
    '{'{MODE_UNUSED, 16'hFFFF, 1'b1, 2'd3, 1'b1, 1'b1, 14'h3FFF, 8'hFF}, 1'b0, 8'h00},
    // entry writes at both key extremes, read back
    '{'{MODE_WRITE,  16'h0000, 1'b0, 2'd0, 1'b0, 1'b0, 14'h3FFF, 8'hA5}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'hE0E7, 1'b1, 2'd3, 1'b1, 1'b1, 14'h0000, 8'h00}, 1'b1, 8'hA5},
    '{'{MODE_WRITE,  16'hFFFF, 1'b1, 2'd3, 1'b1, 1'b1, 14'h0000, 8'h5A}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h0000, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b1, 8'h5A},
    // restore brings both entries back to their defaults; key zero is read back
    '{'{MODE_RESTORE, 16'h0000, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b0, 8'h00},
    '{'{MODE_LOOKUP, 16'h0000, 1'b0, 2'd0, 1'b0, 1'b0, 14'h0000, 8'h00}, 1'b1, 8'h00}
  };

  io_port_decode_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Built-in code of one port and direction. It has no 0xFE or 0xFD arm:
  // the 0xC0-and-above rule covers those low bytes.
  function automatic logic [7:0] port_default(input logic [15:0] port, input logic rd);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = port[7:0];
    hi = port[15:8];
    if (lo >= 8'hC0) return lo;
    if (lo == 8'h1C && rd && hi < 8'h80) return 8'h1C;
    if (lo == 8'h1D && !rd && hi < 8'h80) return 8'h1D;
    if (lo == 8'h1E && !rd && hi < 8'h80) return 8'h1E;
    if (lo == 8'hBD && rd && hi == 8'hFF) return 8'h1C;
    if (lo == 8'hBD && !rd && hi == 8'hDF) return 8'h1D;
    if (lo == 8'hBD && !rd && hi == 8'hBF) return 8'h1E;
    if (lo == 8'h82 && !rd && hi < 8'h80) return 8'hE8;
    if (lo == 8'hA2 && !rd && hi < 8'h80) return 8'hE9;
    if (lo >= 8'h50 && lo <= 8'h57) return 8'h20 + (lo - 8'h50);
    case (lo)
      8'h1F: return 8'h10;
      8'h3F: return 8'h11;
      8'h5F: return 8'h12;
      8'h7F: return 8'h13;
      8'h88, 8'h89, 8'h8F: return lo;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [9:0] low_part(input logic rd, input logic [15:0] port);
    return {rd, port[15:14], port[6:5], port[13], port[7], port[2:0]};
  endfunction

  // Lookup that hits a given key; free port bits are random
  function automatic io_item_t lookup_of_key(input logic [13:0] key);
    io_item_t it;
    it.mode        = MODE_LOOKUP;
    it.port        = 16'($urandom);
    it.port[15:14] = key[8:7];
    it.port[6:5]   = key[6:5];
    it.port[13]    = key[4];
    it.port[7]     = key[3];
    it.port[2:0]   = key[2:0];
    it.rd          = key[9];
    it.cfg         = key[13:12];
    it.page        = key[11];
    it.dos         = key[10];
    it.ekey        = 14'($urandom);
    it.eval        = 8'($urandom);
    return it;
  endfunction

  // Random transaction, weighted toward lookups of decoded ports and written keys
  function automatic io_item_t random_item();
    io_item_t it;
    logic [7:0] lo_pick [20] = '{8'h00, 8'hFE, 8'hFD, 8'hBD, 8'h1C, 8'h1D, 8'h1E, 8'h82,
                                 8'hA2, 8'h50, 8'h57, 8'h1F, 8'h3F, 8'h5F, 8'h7F, 8'h88,
                                 8'h89, 8'h8F, 8'hC0, 8'hFF};
    logic [7:0] hi_pick [5] = '{8'hFF, 8'hDF, 8'hBF, 8'h7F, 8'h00};
    int r;
    it = io_item_t'({$urandom, $urandom});
    r  = $urandom_range(999);
    if (r < 3) begin
      it.mode = MODE_RESTORE;
    end else if (r < 20) begin
      it.mode = MODE_UNUSED;
    end else if (r < 170) begin
      it.mode = MODE_WRITE;
      if ($urandom_range(1) == 1) begin
        written_keys.push_back(it.ekey);
        if (written_keys.size() > 16) void'(written_keys.pop_front());
      end
    end else if (r < 320 && written_keys.size() > 0) begin
      it = lookup_of_key(written_keys[$urandom_range(written_keys.size() - 1)]);
    end else if (r < 520) begin
      it.mode = MODE_LOOKUP;
    end else begin
      it.mode = MODE_LOOKUP;
      it.port[7:0] = lo_pick[$urandom_range(19)];
      if ($urandom_range(2) != 0) it.port[15:8] = hi_pick[$urandom_range(4)];
    end
    return it;
  endfunction

  // Advance the predicted table by one accepted transaction
  task automatic decode_apply(input io_item_t it, output bit produced, output decode_res_t res);
    produced = 1'b0;
    res      = '0;
    case (it.mode)
      MODE_LOOKUP: begin
        res.key  = {it.cfg, it.page, it.dos, low_part(it.rd, it.port)};
        res.code = dev_table[res.key];
        produced = 1'b1;
      end
      MODE_WRITE: begin
        dev_table[it.ekey] = it.eval;
      end
      MODE_RESTORE: begin
        for (int k = 0; k < 16384; k++) dev_table[k] = dflt_low[k[9:0]];
      end
      default: begin
      end
    endcase
  endtask

  // Offer one transaction with random idle gaps, then record what it should produce
  task automatic send_item(input io_item_t it, input bit typed, input logic [7:0] code);
    bit          produced;
    decode_res_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {5'b00000, it.eval, it.ekey, it.dos, it.page, it.cfg, it.rd, it.port};
    do @(posedge clk); while (!s_tready);
    decode_apply(it, produced, res);
    if (produced) begin
      if (typed) res.code = code;
      pending_results.push_back(res);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver backpressure
  initial m_tready = 1'b0;
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    decode_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got device_code %h table_key %h",
                 $time, m_tdata[7:0], m_tdata[21:8]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.code) begin
          $display("%0t: device_code mismatch, expected %h, got %h",
                   $time, want.code, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[21:8] !== want.key) begin
          $display("%0t: table_key mismatch, expected %h, got %h",
                   $time, want.key, m_tdata[21:8]);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("io_port_decode_table_tb: FAIL");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [9:0] lk;
    logic [7:0] c;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    errors    = 0;
    steady    = 1'b0;
    stim_done = 1'b0;

    // Defaults: walk both directions and every port, last nonzero code wins
    for (int k = 0; k < 1024; k++) dflt_low[k] = 8'h00;
    for (int rd = 0; rd < 2; rd++) begin
      for (int p = 0; p < 65536; p++) begin
        c = port_default(16'(p), 1'(rd));
        if (c != 8'h00) begin
          lk = low_part(1'(rd), 16'(p));
          dflt_low[lk] = c;
        end
      end
    end
    for (int k = 0; k < 16384; k++) dev_table[k] = dflt_low[k[9:0]];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed[i].item, directed[i].typed, directed[i].code);
    end

    // Random part with one stretch of full throughput on both sides
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 300 && i < 520);
      send_item(random_item(), 1'b0, 8'h00);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    stim_done = 1'b1;

    // Drain outstanding results, then let trailing work settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("io_port_decode_table_tb: PASS");
    end else begin
      $display("io_port_decode_table_tb: FAIL");
    end
    $finish;
  end

endmodule
